### rtl/core/ppt_pkg.sv
// shared types and constants for the point in polygon test block
package ppt_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int COORD_WIDTH_DEF  = 16;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN
  } ppt_state_t;

  // control that travels with one edge into the edge unit
  typedef struct packed {
    logic valid;
    logic last;
  } ppt_edge_ctl_t;

  // verdict that comes back for one edge
  typedef struct packed {
    logic valid;
    logic last;
    logic toggle;
  } ppt_edge_res_t;

endpackage

### rtl/core/ppt_edge_unit.sv
// two stage edge evaluator: differences, cross products, crossing decision
module ppt_edge_unit import ppt_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ppt_edge_ctl_t                 edge_ctl,
  input  logic signed [COORD_WIDTH-1:0] px,
  input  logic signed [COORD_WIDTH-1:0] py,
  input  logic signed [COORD_WIDTH-1:0] xi,
  input  logic signed [COORD_WIDTH-1:0] yi,
  input  logic signed [COORD_WIDTH-1:0] xj,
  input  logic signed [COORD_WIDTH-1:0] yj,
  output ppt_edge_res_t                 edge_res
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  ppt_edge_ctl_t        s1_ctl_r;
  logic                 s1_straddle_r;
  logic                 s1_dpos_r;
  logic signed [DW-1:0] a_r;
  logic signed [DW-1:0] b_r;
  logic signed [DW-1:0] c_r;
  logic signed [DW-1:0] d_r;

  ppt_edge_ctl_t        s2_ctl_r;
  logic                 s2_straddle_r;
  logic                 s2_dpos_r;
  logic signed [PW-1:0] p_ad_r;
  logic signed [PW-1:0] p_bc_r;

  logic signed [DW-1:0] a_nxt;
  logic signed [DW-1:0] b_nxt;
  logic signed [DW-1:0] c_nxt;
  logic signed [DW-1:0] d_nxt;
  logic                 straddle_nxt;
  logic                 left;

  always_comb begin
    a_nxt        = DW'(px) - DW'(xi);
    b_nxt        = DW'(xj) - DW'(xi);
    c_nxt        = DW'(py) - DW'(yi);
    d_nxt        = DW'(yj) - DW'(yi);
    straddle_nxt = (yi > py) != (yj > py);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
    end else begin
      s1_ctl_r <= edge_ctl;
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r           <= a_nxt;
    b_r           <= b_nxt;
    c_r           <= c_nxt;
    d_r           <= d_nxt;
    s1_straddle_r <= straddle_nxt;
    s1_dpos_r     <= d_nxt > 0;
    p_ad_r        <= a_r * d_r;
    p_bc_r        <= b_r * c_r;
    s2_straddle_r <= s1_straddle_r;
    s2_dpos_r     <= s1_dpos_r;
  end

  // dividing through by d flips the comparison when d is negative
  always_comb begin
    left            = s2_dpos_r ? (p_ad_r < p_bc_r) : (p_bc_r < p_ad_r);
    edge_res.valid  = s2_ctl_r.valid;
    edge_res.last   = s2_ctl_r.last;
    edge_res.toggle = s2_straddle_r & left;
  end

endmodule

### rtl/core/point_in_polygon_test.sv
// top level of the point in polygon crossing test
//
// One input channel: an item is taken when start is high and busy is low.
// A store item (opcode 0) writes one vertex into the polygon memory in the
// cycle it is taken; it gives no result and busy stays low, so stores run
// at one item per cycle. A store to a slot at or above MAX_VERTICES is
// dropped.
// A query item (opcode 1) with a nonzero count raises busy and walks the edges
// of the first vertex_count vertices (count saturates at MAX_VERTICES). The
// memory is read at one address per cycle, the previous vertex is kept in a
// register and each edge runs through a two stage difference and cross
// product unit, one edge per cycle. A query of count n makes n + 1 memory
// reads, then waits in the drain state for the last edge to leave the edge
// unit; out_valid pulses in the same cycle that busy falls. A query with count
// zero gives inside 0 in the cycle after it is taken.
// Each result is shown for one cycle on out_valid / out_inside_res; the
// receiver cannot stall it, and a new item may be taken while it shows.
// Reset clears the sequencer and strobes; the vertex memory is not cleared
// and must be written before a query reads it.
module point_in_polygon_test import ppt_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  localparam int IDX_W = $clog2(MAX_VERTICES),
  localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_opcode,
  input  logic [IDX_W-1:0]              in_vertex_index,
  input  logic signed [COORD_WIDTH-1:0] in_coord_x,
  input  logic signed [COORD_WIDTH-1:0] in_coord_y,
  input  logic [CNT_W-1:0]              in_vertex_count,
  output logic                          out_valid,
  output logic                          out_inside_res
);

  logic signed [COORD_WIDTH-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] mem_y [MAX_VERTICES];

  ppt_state_t state_r, state_nxt;

  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [CNT_W-1:0]              step_r, step_nxt;
  logic signed [COORD_WIDTH-1:0] px_r, px_nxt;
  logic signed [COORD_WIDTH-1:0] py_r, py_nxt;
  logic                          inside_r, inside_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_inside_r, out_inside_nxt;

  logic                          accept;
  logic                          wr_en;
  logic                          rd_en;
  logic [IDX_W-1:0]              rd_addr;
  logic [CNT_W-1:0]              cnt_sat;

  logic                          rd_vld_r;
  logic                          rd_first_r;
  logic                          rd_last_r;
  logic signed [COORD_WIDTH-1:0] rd_x_r;
  logic signed [COORD_WIDTH-1:0] rd_y_r;
  logic signed [COORD_WIDTH-1:0] prev_x_r;
  logic signed [COORD_WIDTH-1:0] prev_y_r;

  ppt_edge_ctl_t edge_ctl;
  ppt_edge_res_t edge_res;

  assign busy   = state_r != ST_IDLE;
  assign accept = start & ~busy;
  assign wr_en  = accept & (in_opcode == OP_STORE) &
                  ({1'b0, in_vertex_index} < (IDX_W + 1)'(MAX_VERTICES));

  assign cnt_sat = (in_vertex_count > CNT_W'(MAX_VERTICES)) ?
                   CNT_W'(MAX_VERTICES) : in_vertex_count;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[in_vertex_index] <= in_coord_x;
      mem_y[in_vertex_index] <= in_coord_y;
    end
  end

  // first read fetches the closing vertex, then vertices 0 .. count-1
  assign rd_en   = state_r == ST_READ;
  assign rd_addr = (step_r == '0) ? IDX_W'(cnt_r - CNT_W'(1)) :
                                    IDX_W'(step_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_x_r <= mem_x[rd_addr];
      rd_y_r <= mem_y[rd_addr];
    end
    if (rd_vld_r) begin
      prev_x_r <= rd_x_r;
      prev_y_r <= rd_y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_first_r <= step_r == '0;
    rd_last_r  <= step_r == cnt_r;
  end

  assign edge_ctl.valid = rd_vld_r & ~rd_first_r;
  assign edge_ctl.last  = rd_last_r;

  ppt_edge_unit #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_edge (
    .clk      (clk),
    .rst_n    (rst_n),
    .edge_ctl (edge_ctl),
    .px       (px_r),
    .py       (py_r),
    .xi       (rd_x_r),
    .yi       (rd_y_r),
    .xj       (prev_x_r),
    .yj       (prev_y_r),
    .edge_res (edge_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    step_r       <= step_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    inside_r     <= inside_nxt;
    out_inside_r <= out_inside_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    step_nxt       = step_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    inside_nxt     = inside_r;
    out_valid_nxt  = 1'b0;
    out_inside_nxt = out_inside_r;

    if (edge_res.valid) begin
      inside_nxt = inside_r ^ edge_res.toggle;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_opcode == OP_QUERY) begin
          px_nxt     = in_coord_x;
          py_nxt     = in_coord_y;
          cnt_nxt    = cnt_sat;
          step_nxt   = '0;
          inside_nxt = 1'b0;
          if (cnt_sat == '0) begin
            out_valid_nxt  = 1'b1;
            out_inside_nxt = 1'b0;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        step_nxt = step_r + CNT_W'(1);
        if (step_r == cnt_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (edge_res.valid && edge_res.last) begin
          out_valid_nxt  = 1'b1;
          out_inside_nxt = inside_r ^ edge_res.toggle;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;

endmodule

### tb/sv/point_in_polygon_test_test.sv
// self-checking testbench for the point in polygon crossing test block
`timescale 1ns / 100ps

module point_in_polygon_test_test import ppt_pkg::*;;

  typedef logic signed [15:0] coord_t;

  class parity_scoreboard;
    coord_t poly_x[16];
    coord_t poly_y[16];
    bit     inside_exp_q[$];
    int     errors;

    function automatic bit crossing_parity(coord_t px, coord_t py, logic [4:0] cnt);
      int     n;
      int     i;
      int     j;
      longint xi, yi, xj, yj, a, b, c, d;
      bit     in_poly;
      bit     left;
      n = (cnt > 16) ? 16 : int'(cnt);
      in_poly = 1'b0;
      j = n - 1;
      for (i = 0; i < n; i++) begin
        xi = poly_x[i];
        yi = poly_y[i];
        xj = poly_x[j];
        yj = poly_y[j];
        if ((yi > py) != (yj > py)) begin
          a = px - xi;
          d = yj - yi;
          b = xj - xi;
          c = py - yi;
          // crossing x compared without division, direction follows sign of d
          left = (d > 0) ? (a * d < b * c) : (b * c < a * d);
          if (left) in_poly = !in_poly;
        end
        j = i;
      end
      return in_poly;
    endfunction

    function void note_item(logic op, logic [3:0] idx, coord_t x, coord_t y, logic [4:0] cnt);
      if (op == OP_STORE) begin
        poly_x[idx] = x;
        poly_y[idx] = y;
      end else begin
        inside_exp_q.push_back(crossing_parity(x, y, cnt));
      end
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic got);
      bit want;
      if (inside_exp_q.size() == 0) begin
        report_mismatch($sformatf("inside_res %b with no query waiting", got));
      end else begin
        want = inside_exp_q.pop_front();
        if (got !== want)
          report_mismatch($sformatf("inside_res %b, expected %b", got, want));
      end
    endtask

    function int pending();
      return inside_exp_q.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       in_opcode;
  logic [3:0] in_vertex_index;
  coord_t     in_coord_x;
  coord_t     in_coord_y;
  logic [4:0] in_vertex_count;
  logic       out_valid;
  logic       out_inside_res;

  parity_scoreboard sb = new();
  bit [15:0] slot_written;
  int        items_sent;

  point_in_polygon_test i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_vertex_index (in_vertex_index),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_vertex_count (in_vertex_count),
    .out_valid       (out_valid),
    .out_inside_res  (out_inside_res)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  // results are checked before the item taken at the same edge is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_inside_res);
      if (start && !busy)
        sb.note_item(in_opcode, in_vertex_index, in_coord_x, in_coord_y, in_vertex_count);
    end
  end

  function automatic coord_t rand_coord(int mode);
    int pick;
    case (mode)
      0: return coord_t'($urandom_range(0, 65535));
      1: return coord_t'(int'($urandom_range(0, 16)) - 8);
      2: return coord_t'(int'($urandom_range(0, 4000)) - 2000);
      default: begin
        pick = $urandom_range(0, 5);
        case (pick)
          0: return coord_t'(-32768);
          1: return coord_t'(32767);
          2: return coord_t'(0);
          3: return coord_t'(-1);
          4: return coord_t'(1);
          default: return coord_t'(-32767);
        endcase
      end
    endcase
  endfunction

  function automatic int written_prefix();
    int i;
    i = 0;
    while (i < 16 && slot_written[i]) i++;
    return i;
  endfunction

  task automatic issue(logic op, logic [3:0] idx, coord_t x, coord_t y, logic [4:0] cnt);
    start           <= 1'b1;
    in_opcode       <= op;
    in_vertex_index <= idx;
    in_coord_x      <= x;
    in_coord_y      <= y;
    in_vertex_count <= cnt;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == OP_STORE) slot_written[idx] = 1'b1;
    items_sent++;
    // a stretch of items with no idling at all
    if (!(items_sent >= 700 && items_sent < 1000) && $urandom_range(0, 99) < 16) begin
      start           <= 1'b0;
      in_opcode       <= 1'($urandom());
      in_vertex_index <= 4'($urandom());
      in_coord_x      <= coord_t'($urandom());
      in_coord_y      <= coord_t'($urandom());
      in_vertex_count <= 5'($urandom());
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  endtask

  initial begin
    int     n;
    int     mode;
    int     k;
    int     km1;
    int     s;
    int     q;
    int     nq;
    int     kind;
    int     cnt;
    int     prefix;
    bit     rev;
    bit     first;
    coord_t px;
    coord_t py;

    rst_n           = 1'b0;
    start           = 1'b0;
    in_opcode       = OP_STORE;
    in_vertex_index = '0;
    in_coord_x      = '0;
    in_coord_y      = '0;
    in_vertex_count = '0;
    slot_written    = '0;
    items_sent      = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full-range square, horizontal top and bottom edges
    issue(OP_STORE, 4'd0, -16'sd32768, -16'sd32768, 5'd0);
    issue(OP_STORE, 4'd1, 16'sd32767, -16'sd32768, 5'd31);
    issue(OP_STORE, 4'd2, 16'sd32767, 16'sd32767, 5'd0);
    issue(OP_STORE, 4'd3, -16'sd32768, 16'sd32767, 5'd31);
    issue(OP_QUERY, 4'd15, 16'sd0, 16'sd0, 5'd4);
    // points exactly on the left and right crossings and on the top and bottom edges
    issue(OP_QUERY, 4'd0, -16'sd32768, 16'sd0, 5'd4);
    issue(OP_QUERY, 4'd0, 16'sd32767, 16'sd0, 5'd4);
    issue(OP_QUERY, 4'd0, 16'sd0, 16'sd32767, 5'd4);
    issue(OP_QUERY, 4'd0, 16'sd0, -16'sd32768, 5'd4);
    // count zero walks no edges; counts one and two walk degenerate polygons
    issue(OP_QUERY, 4'd9, 16'sd0, 16'sd0, 5'd0);
    issue(OP_QUERY, 4'd0, 16'sd0, 16'sd0, 5'd1);
    issue(OP_QUERY, 4'd0, 16'sd0, 16'sd0, 5'd2);
    // right triangle, points on the slanted edge, strictly inside, just inside the slant and just outside the left edge
    issue(OP_STORE, 4'd0, 16'sd0, 16'sd0, 5'd0);
    issue(OP_STORE, 4'd1, 16'sd1024, 16'sd0, 5'd0);
    issue(OP_STORE, 4'd2, 16'sd0, 16'sd1024, 5'd0);
    issue(OP_QUERY, 4'd0, 16'sd512, 16'sd512, 5'd3);
    issue(OP_QUERY, 4'd0, 16'sd256, 16'sd256, 5'd3);
    issue(OP_QUERY, 4'd0, 16'sd511, 16'sd512, 5'd3);
    issue(OP_QUERY, 4'd0, -16'sd1, 16'sd512, 5'd3);

    first = 1'b1;
    while (items_sent < 1900) begin
      if (first) n = 16;
      else if ($urandom_range(0, 9) == 0) n = 16;
      else if ($urandom_range(0, 19) == 0) n = $urandom_range(1, 2);
      else n = $urandom_range(3, 12);
      first = 1'b0;
      mode = $urandom_range(0, 3);
      rev = ($urandom_range(0, 3) == 0);
      for (k = 0; k < n; k++) begin
        s = rev ? n - 1 - k : k;
        issue(OP_STORE, 4'(s), rand_coord(mode), rand_coord(mode), 5'($urandom()));
        // stray store into any slot
        if ($urandom_range(0, 15) == 0)
          issue(OP_STORE, 4'($urandom()), rand_coord(mode), rand_coord(mode),
                5'($urandom()));
      end
      nq = $urandom_range(2, 10);
      for (q = 0; q < nq; q++) begin
        k = $urandom_range(0, n - 1);
        km1 = (k == 0) ? n - 1 : k - 1;
        kind = $urandom_range(0, 9);
        case (kind)
          4: begin
            px = sb.poly_x[k];
            py = sb.poly_y[k];
          end
          5: begin
            px = rand_coord(mode);
            py = sb.poly_y[k];
          end
          6: begin
            // midpoint of an edge, often right on the crossing
            px = coord_t'((longint'(sb.poly_x[k]) + longint'(sb.poly_x[km1])) >>> 1);
            py = coord_t'((longint'(sb.poly_y[k]) + longint'(sb.poly_y[km1])) >>> 1);
          end
          7: begin
            px = rand_coord(0);
            py = rand_coord(0);
          end
          default: begin
            px = rand_coord(mode);
            py = rand_coord(mode);
          end
        endcase
        prefix = written_prefix();
        case ($urandom_range(0, 9))
          7, 8: cnt = $urandom_range(0, prefix);
          9: cnt = (prefix == 16) ? $urandom_range(16, 31) : prefix;
          default: cnt = n;
        endcase
        issue(OP_QUERY, 4'($urandom()), px, py, 5'(cnt));
      end
    end

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/ppt_pkg.sv
rtl/core/ppt_edge_unit.sv
rtl/core/point_in_polygon_test.sv
tb/sv/point_in_polygon_test_test.sv
